### src/spn_pkg.sv
// Shared types, constants and table functions for the 8-bit SPN cipher core.
package spn_pkg;

    // Widths fixed by the block and its register map.
    localparam int BLK_W      = 8;
    localparam int RND_W      = 4;
    localparam int KEY_W      = 40;
    localparam int SBOX_W     = 64;
    localparam int PBOX_W     = 24;
    localparam int KS_W       = RND_W + 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Default number of round cells in the chain.
    localparam int SPN_MAX_ROUNDS = 8;

    // Reset value of the round count register.
    localparam logic [RND_W-1:0] RND_RESET = RND_W'(4);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUND_COUNT = 2'd0,
        CFG_KEY_BITS    = 2'd1,
        CFG_SBOX_TABLE  = 2'd2,
        CFG_PBOX_TABLE  = 2'd3
    } t_cfg_idx;

    // Settings seen by every round cell.
    typedef struct packed {
        logic [RND_W-1:0]  n_rounds;
        logic [KEY_W-1:0]  key;
        logic [SBOX_W-1:0] fwd_sbox;
        logic [PBOX_W-1:0] fwd_pbox;
        logic [SBOX_W-1:0] inv_sbox;
        logic [PBOX_W-1:0] inv_pbox;
    } t_cfg;

    // Round key: digit start+i lands on byte position i (position 0 is the MSB).
    function automatic logic [BLK_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [KS_W-1:0]  start);
        logic [63:0]      sh;
        logic [BLK_W-1:0] k;
        sh = {24'd0, key} >> start;
        for (int i = 0; i < BLK_W; i++) begin
            k[BLK_W-1-i] = sh[i];
        end
        return k;
    endfunction

    // Both nibbles through a 4-bit S-box.
    function automatic logic [BLK_W-1:0] sub_byte(input logic [BLK_W-1:0]  b,
                                                  input logic [SBOX_W-1:0] s);
        return {s[4*b[7:4] +: 4], s[4*b[3:0] +: 4]};
    endfunction

    // Output position i takes the source position held in bits 3i+2..3i.
    function automatic logic [BLK_W-1:0] perm_byte(input logic [BLK_W-1:0]  b,
                                                   input logic [PBOX_W-1:0] p);
        logic [BLK_W-1:0] r;
        logic [2:0]       src;
        for (int i = 0; i < BLK_W; i++) begin
            src          = p[3*i +: 3];
            r[BLK_W-1-i] = b[BLK_W-1-src];
        end
        return r;
    endfunction

    // Inverse S-box: unmapped entries are zero, the highest matching index wins.
    function automatic logic [SBOX_W-1:0] inv_sbox(input logic [SBOX_W-1:0] s);
        logic [SBOX_W-1:0] r;
        r = '0;
        for (int v = 0; v < 16; v++) begin
            for (int i = 0; i < 16; i++) begin
                if (s[4*i +: 4] == 4'(v)) begin
                    r[4*v +: 4] = 4'(i);
                end
            end
        end
        return r;
    endfunction

    // Inverse P-box with the same rules as the inverse S-box.
    function automatic logic [PBOX_W-1:0] inv_pbox(input logic [PBOX_W-1:0] p);
        logic [PBOX_W-1:0] r;
        r = '0;
        for (int v = 0; v < 8; v++) begin
            for (int i = 0; i < 8; i++) begin
                if (p[3*i +: 3] == 3'(v)) begin
                    r[3*v +: 3] = 3'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

### src/spn_cfg.sv
// Configuration registers, round count clamping and inverse table derivation.
module spn_cfg #(
    parameter int MAX_ROUNDS = spn_pkg::SPN_MAX_ROUNDS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output spn_pkg::t_cfg                      o_cfg
);
    import spn_pkg::*;

    localparam logic [RND_W-1:0] MAX_N = RND_W'(MAX_ROUNDS);

    logic [RND_W-1:0]  r_rounds;
    logic [KEY_W-1:0]  r_key;
    logic [SBOX_W-1:0] r_sbox;
    logic [PBOX_W-1:0] r_pbox;
    logic [RND_W-1:0]  n_clamped;

    // Register writes; no wait and no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= RND_RESET;
            r_key    <= '0;
            r_sbox   <= '0;
            r_pbox   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROUND_COUNT: r_rounds <= i_cfg_data[RND_W-1:0];
                CFG_KEY_BITS:    r_key    <= i_cfg_data[KEY_W-1:0];
                CFG_SBOX_TABLE:  r_sbox   <= i_cfg_data[SBOX_W-1:0];
                CFG_PBOX_TABLE:  r_pbox   <= i_cfg_data[PBOX_W-1:0];
                default:         r_rounds <= r_rounds;
            endcase
        end
    end

    // A round count of zero runs one round; values above the chain length saturate.
    always_comb begin
        priority if (r_rounds == '0) begin
            n_clamped = RND_W'(1);
        end else if (r_rounds > MAX_N) begin
            n_clamped = MAX_N;
        end else begin
            n_clamped = r_rounds;
        end
    end

    assign o_cfg.n_rounds = n_clamped;
    assign o_cfg.key      = r_key;
    assign o_cfg.fwd_sbox = r_sbox;
    assign o_cfg.fwd_pbox = r_pbox;
    assign o_cfg.inv_sbox = inv_sbox(r_sbox);
    assign o_cfg.inv_pbox = inv_pbox(r_pbox);

endmodule

### src/spn_cell.sv
// One round cell of the chain: one cipher round and one pipeline register.
module spn_cell #(
    parameter int CELL_IDX = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  spn_pkg::t_cfg               i_cfg,
    input  logic                        i_vld,
    input  logic                        i_cmd,
    input  logic [spn_pkg::BLK_W-1:0]   i_x,
    output logic                        o_vld,
    output logic                        o_cmd,
    output logic [spn_pkg::BLK_W-1:0]   o_x
);
    import spn_pkg::*;

    localparam logic [RND_W-1:0] CELL_J = RND_W'(CELL_IDX);

    logic             r_vld;
    logic             r_cmd;
    logic [BLK_W-1:0] r_x;
    logic [BLK_W-1:0] n_x;
    logic [RND_W-1:0] rnd;
    logic [KS_W-1:0]  kstart;
    logic [BLK_W-1:0] rkey;
    logic             active;
    logic             last;
    logic [BLK_W-1:0] t_a;
    logic [BLK_W-1:0] t_b;

    // Encryption walks rounds upward along the chain, decryption downward.
    always_comb begin
        active = (CELL_J <= i_cfg.n_rounds);
        rnd    = i_cmd ? (i_cfg.n_rounds - CELL_J + RND_W'(1)) : CELL_J;
        last   = (rnd == i_cfg.n_rounds);
        kstart = {rnd - RND_W'(1), 2'b00};
        rkey   = key_byte(i_cfg.key, kstart);
    end

    // Round datapath; cells past the round count pass the byte through.
    always_comb begin
        if (!i_cmd) begin
            t_a = sub_byte(i_x ^ rkey, i_cfg.fwd_sbox);
            t_b = last ? t_a : perm_byte(t_a, i_cfg.fwd_pbox);
        end else begin
            t_a = last ? i_x : perm_byte(i_x, i_cfg.inv_pbox);
            t_b = sub_byte(t_a, i_cfg.inv_sbox) ^ rkey;
        end
        n_x = active ? t_b : i_x;
    end

    // Valid travels with the byte and its direction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cmd <= i_cmd;
            r_x   <= n_x;
        end
    end

    assign o_vld = r_vld;
    assign o_cmd = r_cmd;
    assign o_x   = r_x;

endmodule

### src/spn_block_cipher_8bit_core.sv
// Top level of the 8-bit SPN block cipher core: round cell chain and output register.
//
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_stall      i_cmd, i_block_in
//  result    out        o_valid / i_stall      o_block_out
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// One block enters per cycle while the chain is not stalled and passes through one
// register in each round cell of the chain and then the output register.
// Rounds beyond the configured count pass the byte through their cell unchanged.
// Reset is synchronous and clears all valid bits and loads the register defaults.
// A stalled result freezes the whole chain, so o_stall follows o_valid and i_stall.
module spn_block_cipher_8bit_core #(
    parameter int MAX_ROUNDS = spn_pkg::SPN_MAX_ROUNDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cmd,
    input  logic [spn_pkg::BLK_W-1:0]        i_block_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [spn_pkg::BLK_W-1:0]        o_block_out,
    input  logic                             i_cfg_we,
    input  logic [spn_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import spn_pkg::*;

    t_cfg             cfg;
    logic             adv;
    logic [BLK_W-1:0] whiten;
    logic             w_vld [0:MAX_ROUNDS];
    logic             w_cmd [0:MAX_ROUNDS];
    logic [BLK_W-1:0] w_x   [0:MAX_ROUNDS];
    logic             r_out_vld;
    logic [BLK_W-1:0] r_out_x;

    spn_cfg #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The chain moves unless a finished result is held by the receiver.
    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;

    // Whitening key sits after the last round of encryption, before the first of decryption.
    assign whiten   = key_byte(cfg.key, {cfg.n_rounds, 2'b00});
    assign w_vld[0] = i_valid;
    assign w_cmd[0] = i_cmd;
    assign w_x[0]   = i_cmd ? (i_block_in ^ whiten) : i_block_in;

    // Row of round cells.
    for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_cell
        spn_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cfg   (cfg),
            .i_vld   (w_vld[g-1]),
            .i_cmd   (w_cmd[g-1]),
            .i_x     (w_x[g-1]),
            .o_vld   (w_vld[g]),
            .o_cmd   (w_cmd[g]),
            .o_x     (w_x[g])
        );
    end

    // Output register with the closing whitening step of encryption.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= w_vld[MAX_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x <= w_cmd[MAX_ROUNDS] ? w_x[MAX_ROUNDS] : (w_x[MAX_ROUNDS] ^ whiten);
        end
    end

    assign o_valid     = r_out_vld;
    assign o_block_out = r_out_x;

    // No result survives a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A transaction leaving the last cell while the chain moves reaches the output.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[MAX_ROUNDS] && adv) |=> o_valid)
        else $error("transaction lost between last cell and output register");

    // The effective round count always names an existing cell.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg.n_rounds != '0) && (cfg.n_rounds <= RND_W'(MAX_ROUNDS)))
        else $error("round count outside the cell chain");

endmodule
